FILE: hw/rtl/lmn_pkg.sv
// Shared types, codes and helpers for the Lamport mutual-exclusion node.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lmn_pkg;

   // Number of participating nodes, and the width of a slot index.
   localparam int unsigned NODES  = 3;
   localparam int unsigned IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;

   // Fixed field widths.
   localparam int unsigned ID_W   = 4;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned SEND_W = 3;
   localparam int unsigned STAT_W = 2;

   localparam logic [TIME_W-1:0] CLOCK_MAX = '1;
   localparam logic [ID_W:0]     NODES_LIM = (ID_W + 1)'(NODES);

   // Event kinds.
   localparam logic [KIND_W-1:0] EV_TICK       = 3'd0;
   localparam logic [KIND_W-1:0] EV_LOCAL_REQ  = 3'd1;
   localparam logic [KIND_W-1:0] EV_LOCAL_REL  = 3'd2;
   localparam logic [KIND_W-1:0] EV_PEER_REQ   = 3'd3;
   localparam logic [KIND_W-1:0] EV_PEER_REL   = 3'd4;
   localparam logic [KIND_W-1:0] EV_PEER_REPLY = 3'd5;

   // Outgoing message kinds.
   localparam logic [SEND_W-1:0] SEND_NONE    = 3'd0;
   localparam logic [SEND_W-1:0] SEND_REQUEST = 3'd1;
   localparam logic [SEND_W-1:0] SEND_RELEASE = 3'd2;
   localparam logic [SEND_W-1:0] SEND_REPLY   = 3'd3;
   localparam logic [SEND_W-1:0] SEND_ENTERED = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_ALREADY   = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_REQ    = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   sender;
      logic [TIME_W-1:0] msg_time;
   } lmn_event_type;

   typedef struct packed {
      logic [SEND_W-1:0] send_kind;
      logic [TIME_W-1:0] send_time;
      logic [ID_W-1:0]   send_dest;
      logic [TIME_W-1:0] clock_now;
      logic              entered;
      logic [STAT_W-1:0] status;
   } lmn_result_type;

   // Saturating Lamport clock increment.
   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
      return (v == CLOCK_MAX) ? v : v + TIME_W'(1);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lmn_in_stage.sv
// Input register of the mutex node: holds one accepted event.
// Depends on lmn_pkg.
`default_nettype none

module lmn_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [lmn_pkg::KIND_W-1:0] req_kind,
   input  wire logic [lmn_pkg::ID_W-1:0]   req_sender,
   input  wire logic [lmn_pkg::TIME_W-1:0] req_msg_time,
   input  wire logic                      out_free,
   output logic                           fire,
   output lmn_pkg::lmn_event_type         evt
);
   import lmn_pkg::*;

   logic          valid_ff, valid_in;
   lmn_event_type evt_ff;
   logic          take;

   assign fire      = valid_ff && out_free;
   assign req_stall = valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign evt       = evt_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         evt_ff.kind     <= req_kind;
         evt_ff.sender   <= req_sender;
         evt_ff.msg_time <= req_msg_time;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lmn_core.sv
// Node state and per-event update: Lamport clock, request queue, replies.
// Depends on lmn_pkg.
`default_nettype none

module lmn_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire lmn_pkg::lmn_event_type   evt,
   input  wire logic                     csr_wr_en,
   input  wire logic [lmn_pkg::ID_W-1:0] csr_wr_data,
   output lmn_pkg::lmn_result_type       result
);
   import lmn_pkg::*;

   logic [ID_W-1:0]   node_id_ff;
   logic [TIME_W-1:0] clk_ff, clk_in;
   logic [NODES-1:0]  qv_ff, qv_in;
   logic [TIME_W-1:0] qt_ff [NODES];
   logic [TIME_W-1:0] qt_in [NODES];
   logic [TIME_W-1:0] own_time_ff, own_time_in;
   logic [NODES-1:0]  rv_ff, rv_in, rv_upd;
   logic [TIME_W-1:0] rt_ff [NODES];
   logic [TIME_W-1:0] rt_in [NODES];

   logic [IDX_W-1:0]  own_idx, snd_idx;
   logic              own_ok, peer_ok;
   logic [TIME_W-1:0] local_inc, peer_max, peer_inc;
   logic              ent_check, grant;
   lmn_result_type    res_pre;

   logic              head_found, replies_ok;
   logic [TIME_W-1:0] head_time;
   logic [IDX_W-1:0]  head_idx;

   assign own_idx   = node_id_ff[IDX_W-1:0];
   assign snd_idx   = evt.sender[IDX_W-1:0];
   assign own_ok    = {1'b0, node_id_ff} < NODES_LIM;
   assign peer_ok   = ({1'b0, evt.sender} < NODES_LIM) && (evt.sender != node_id_ff);
   assign local_inc = sat_inc(clk_ff);
   assign peer_max  = (evt.msg_time > clk_ff) ? evt.msg_time : clk_ff;
   assign peer_inc  = sat_inc(peer_max);

   // Event update, before the entry check.
   always_comb begin
      clk_in      = clk_ff;
      qv_in       = qv_ff;
      qt_in       = qt_ff;
      own_time_in = own_time_ff;
      rv_upd      = rv_ff;
      rt_in       = rt_ff;
      ent_check   = 1'b0;
      res_pre     = '0;
      case (evt.kind)
         EV_TICK: begin
            clk_in = local_inc;
         end
         EV_LOCAL_REQ: begin
            if (own_ok) begin
               if (qv_ff[own_idx]) begin
                  res_pre.status = ST_ALREADY;
               end else begin
                  clk_in            = local_inc;
                  qv_in[own_idx]    = 1'b1;
                  qt_in[own_idx]    = local_inc;
                  own_time_in       = local_inc;
                  res_pre.send_kind = SEND_REQUEST;
                  res_pre.send_time = local_inc;
               end
            end
         end
         EV_LOCAL_REL: begin
            if (own_ok) begin
               rv_upd = '0;
               if (!qv_ff[own_idx]) begin
                  res_pre.status = ST_NO_REQ;
               end else begin
                  clk_in            = local_inc;
                  qv_in[own_idx]    = 1'b0;
                  own_time_in       = CLOCK_MAX;
                  res_pre.send_kind = SEND_RELEASE;
                  res_pre.send_time = local_inc;
               end
            end
         end
         EV_PEER_REQ: begin
            if (peer_ok) begin
               clk_in            = peer_inc;
               qv_in[snd_idx]    = 1'b1;
               qt_in[snd_idx]    = evt.msg_time;
               res_pre.send_kind = SEND_REPLY;
               res_pre.send_time = peer_inc;
               res_pre.send_dest = evt.sender;
            end
         end
         EV_PEER_REL: begin
            if (peer_ok) begin
               clk_in         = peer_inc;
               qv_in[snd_idx] = 1'b0;
               ent_check      = own_ok;
            end
         end
         EV_PEER_REPLY: begin
            if (peer_ok) begin
               clk_in         = peer_inc;
               rv_upd[snd_idx] = 1'b1;
               rt_in[snd_idx]  = evt.msg_time;
               ent_check       = own_ok;
            end
         end
         default: begin
         end
      endcase
      res_pre.clock_now = clk_in;
   end

   // Entry check on the updated state: queue head, ties to the lower slot.
   always_comb begin
      head_found = 1'b0;
      head_time  = '0;
      head_idx   = '0;
      replies_ok = 1'b1;
      for (int i = 0; i < NODES; i++) begin
         if (qv_in[i] && (!head_found || qt_in[i] < head_time)) begin
            head_found = 1'b1;
            head_time  = qt_in[i];
            head_idx   = IDX_W'(i);
         end
      end
      for (int i = 0; i < NODES; i++) begin
         if (IDX_W'(i) != own_idx && (!rv_upd[i] || rt_in[i] <= own_time_ff)) begin
            replies_ok = 1'b0;
         end
      end
      grant = ent_check && head_found && (head_idx == own_idx) && replies_ok;
   end

   always_comb begin
      rv_in  = grant ? '0 : rv_upd;
      result = res_pre;
      if (grant) begin
         result.send_kind = SEND_ENTERED;
         result.entered   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff  <= '0;
         clk_ff      <= '0;
         qv_ff       <= '0;
         own_time_ff <= CLOCK_MAX;
         rv_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            node_id_ff <= csr_wr_data;
         end
         if (fire) begin
            clk_ff      <= clk_in;
            qv_ff       <= qv_in;
            own_time_ff <= own_time_in;
            rv_ff       <= rv_in;
         end
      end
   end

   // Timestamps are only read behind their valid bits.
   always_ff @(posedge clock) begin
      if (fire) begin
         qt_ff <= qt_in;
         rt_ff <= rt_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lmn_out_stage.sv
// Result register of the mutex node: holds one result until transferred.
// Depends on lmn_pkg.
`default_nettype none

module lmn_out_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire lmn_pkg::lmn_result_type    result,
   output logic                            out_free,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [lmn_pkg::SEND_W-1:0]      rsp_send_kind,
   output logic [lmn_pkg::TIME_W-1:0]      rsp_send_time,
   output logic [lmn_pkg::ID_W-1:0]        rsp_send_dest,
   output logic [lmn_pkg::TIME_W-1:0]      rsp_clock_now,
   output logic                            rsp_entered,
   output logic [lmn_pkg::STAT_W-1:0]      rsp_status
);
   import lmn_pkg::*;

   logic           valid_ff, valid_in;
   lmn_result_type res_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= result;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_send_kind = res_ff.send_kind;
   assign rsp_send_time = res_ff.send_time;
   assign rsp_send_dest = res_ff.send_dest;
   assign rsp_clock_now = res_ff.clock_now;
   assign rsp_entered   = res_ff.entered;
   assign rsp_status    = res_ff.status;

endmodule

`default_nettype wire

FILE: hw/rtl/lamport_mutex_node_top.sv
// Lamport mutual-exclusion node, top level. Uses lmn_pkg, lmn_in_stage, lmn_core, lmn_out_stage.
// Event held in the input register, then its result in the result register: two register stages.
// One event per cycle unless stalled; state update and queue-head search are combinational.
// Reset (synchronous, active high): clock 0, queue and replies empty, own request time all
// ones, node_id 0, both stages empty. No clearing pass: the block takes events right away.
`default_nettype none

module lamport_mutex_node_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // event channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [lmn_pkg::KIND_W-1:0] req_kind,
   input  wire logic [lmn_pkg::ID_W-1:0]   req_sender,
   input  wire logic [lmn_pkg::TIME_W-1:0] req_msg_time,
   // result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [lmn_pkg::SEND_W-1:0]      rsp_send_kind,
   output logic [lmn_pkg::TIME_W-1:0]      rsp_send_time,
   output logic [lmn_pkg::ID_W-1:0]        rsp_send_dest,
   output logic [lmn_pkg::TIME_W-1:0]      rsp_clock_now,
   output logic                            rsp_entered,
   output logic [lmn_pkg::STAT_W-1:0]      rsp_status,
   // node_id register
   input  wire logic                       csr_wr_en,
   input  wire logic [lmn_pkg::ID_W-1:0]   csr_wr_data
);
   import lmn_pkg::*;

   // fire: the held event is applied to the node state and its result
   // moves into the result register in the same edge.
   logic           fire;
   // out_free: the result register is empty or is being transferred now.
   logic           out_free;
   lmn_event_type  evt;
   lmn_result_type result;

   // Hold one accepted event; stall the sender only while both stages are full
   // and the result side is stalled.
   lmn_in_stage u_in (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_sender   (req_sender),
      .req_msg_time (req_msg_time),
      .out_free     (out_free),
      .fire         (fire),
      .evt          (evt)
   );

   // Advance the clock, queue and reply table; decide entry on the updated state.
   lmn_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .evt         (evt),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   // Register the result; it waits here while the receiver stalls.
   lmn_out_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .result        (result),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_send_kind (rsp_send_kind),
      .rsp_send_time (rsp_send_time),
      .rsp_send_dest (rsp_send_dest),
      .rsp_clock_now (rsp_clock_now),
      .rsp_entered   (rsp_entered),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/lmn_checker.sv
// Port-level checks for the mutex node, bound to lamport_mutex_node_top.
// Depends on lmn_pkg.
`default_nettype none

module lmn_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [lmn_pkg::SEND_W-1:0] rsp_send_kind,
   input wire logic [lmn_pkg::TIME_W-1:0] rsp_send_time,
   input wire logic [lmn_pkg::ID_W-1:0]   rsp_send_dest,
   input wire logic                       rsp_entered,
   input wire logic [lmn_pkg::STAT_W-1:0] rsp_status
);
   import lmn_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Entry is flagged exactly with the entered broadcast.
   a_entered_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entered == (rsp_send_kind == SEND_ENTERED)))
      else $error("entered flag and send kind disagree");

   // Only a reply carries a destination; no message, an entered broadcast or an error means no timestamp.
   a_dest_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_kind != SEND_REPLY |-> rsp_send_dest == '0)
      else $error("destination on a non-reply message");

   a_time_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_send_kind == SEND_NONE || rsp_send_kind == SEND_ENTERED ||
                    rsp_status != ST_OK) |-> rsp_send_time == '0)
      else $error("timestamp on an empty or entered message");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lamport_mutex_node_top lmn_checker u_lmn_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_send_kind (rsp_send_kind),
   .rsp_send_time (rsp_send_time),
   .rsp_send_dest (rsp_send_dest),
   .rsp_entered   (rsp_entered),
   .rsp_status    (rsp_status)
);

`default_nettype wire
